>>> rtl/core/bfd_pkg.sv
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared constants and types for the box filter downscaler.
// ----------------------------------------------------------------------------
package bfd_pkg;

  localparam int unsigned MaxSrcWidth  = 1024;
  localparam int unsigned MaxSrcHeight = 1024;
  localparam int unsigned MaxDstWidth  = 64;

  localparam int unsigned SumW = 28;
  localparam int unsigned PixW = 8;
  localparam int unsigned CfgW = 11;
  localparam int unsigned DwW  = 7;

  // register indexes
  localparam logic [1:0] RegSrcWidth  = 2'd0;
  localparam logic [1:0] RegSrcHeight = 2'd1;
  localparam logic [1:0] RegDstWidth  = 2'd2;
  localparam logic [1:0] RegDstHeight = 2'd3;

  // one RGB triple of running sums
  typedef struct packed {
    logic [SumW-1:0] r;
    logic [SumW-1:0] g;
    logic [SumW-1:0] b;
  } sum_t;

  // request from sequencer to divider
  typedef struct packed {
    logic            start;
    logic [SumW-1:0] r;
    logic [SumW-1:0] g;
    logic [SumW-1:0] b;
    logic [22:0]     area;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [PixW-1:0] r;
    logic [PixW-1:0] g;
    logic [PixW-1:0] b;
  } div_rsp_t;

endpackage

>>> rtl/core/box_filter_image_downscaler_core.sv
// ----------------------------------------------------------------------------
// box_filter_image_downscaler_core
// Area-averaging RGB downscaler with a column-sum memory.
// ----------------------------------------------------------------------------
// Usage:
//  - Source pixels enter on red_i/green_i/blue_i with in_valid_i; a transfer
//    happens when in_valid_i is high and in_stall_o is low.
//  - Destination pixels leave on the out_* ports with out_valid_o; a transfer
//    happens when out_valid_o is high and out_stall_i is low.
//  - Registers are written through the APB port at byte address 4*index.
//    Any write restarts the frame and clears the sums.
// Sequence:
//  - A plain pixel: read of the column-sum memory, then add and write back.
//    A pixel that ends a destination column also waits for the bound unit
//    to compute the next column boundary.
//  - At the end of a row band the bound unit first finds the left box edge;
//    each destination pixel then takes the right box edge, a memory read,
//    the area divide and the output load; the next row band boundary follows.
// Reset and stall:
//  - After reset a clearing pass over the 64-entry memory and the first
//    boundaries run with no input taken; a config write or a frame end
//    repeats it (a write first passes through restart_q).
//  - When out_stall_i is high, hold the finished pixel in the output
//    register and let the sequencer wait.
// ----------------------------------------------------------------------------
module box_filter_image_downscaler_core import bfd_pkg::*; #(
  parameter int unsigned MAX_SRC_WIDTH  = MaxSrcWidth,
  parameter int unsigned MAX_SRC_HEIGHT = MaxSrcHeight,
  parameter int unsigned MAX_DST_WIDTH  = MaxDstWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic [5:0]  dst_col_o,
  output logic [9:0]  dst_row_o,
  output logic        last_of_row_o,
  output logic        last_of_frame_o
);
  localparam int unsigned AW = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b00000000001,
    ST_INIT_C = 11'b00000000010,
    ST_INIT_R = 11'b00000000100,
    ST_IDLE   = 11'b00000001000,
    ST_ACC    = 11'b00000010000,
    ST_CBND   = 11'b00000100000,
    ST_EB0    = 11'b00001000000,
    ST_EB1    = 11'b00010000000,
    ST_ERD    = 11'b00100000000,
    ST_EDIV   = 11'b01000000000,
    ST_EOUT   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [CfgW-1:0] sw_reg_q, sh_reg_q, dh_reg_q;
  logic [DwW-1:0]  dw_reg_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_reg_q <= 11'd64;
      sh_reg_q <= 11'd64;
      dw_reg_q <= 7'd16;
      dh_reg_q <= 11'd16;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegSrcWidth:  sw_reg_q <= pwdata[CfgW-1:0];
        RegSrcHeight: sh_reg_q <= pwdata[CfgW-1:0];
        RegDstWidth:  dw_reg_q <= pwdata[DwW-1:0];
        RegDstHeight: dh_reg_q <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegSrcWidth:  prdata = 32'(sw_reg_q);
      RegSrcHeight: prdata = 32'(sh_reg_q);
      RegDstWidth:  prdata = 32'(dw_reg_q);
      RegDstHeight: prdata = 32'(dh_reg_q);
      default:      prdata = '0;
    endcase
  end

  // effective sizes, registered
  logic [12:0] sw_q, sh_q, dw_q, dh_q;
  logic [12:0] sw_c, sh_c, dwhi_c, dw_c, dh_c;
  always_comb begin
    sw_c = (sw_reg_q == '0) ? 13'd1 :
           (13'(sw_reg_q) > 13'(MAX_SRC_WIDTH)) ? 13'(MAX_SRC_WIDTH) : 13'(sw_reg_q);
    sh_c = (sh_reg_q == '0) ? 13'd1 :
           (13'(sh_reg_q) > 13'(MAX_SRC_HEIGHT)) ? 13'(MAX_SRC_HEIGHT) : 13'(sh_reg_q);
    dwhi_c = (sw_c < 13'(MAX_DST_WIDTH)) ? sw_c : 13'(MAX_DST_WIDTH);
    dw_c = (dw_reg_q == '0) ? 13'd1 : (13'(dw_reg_q) > dwhi_c) ? dwhi_c : 13'(dw_reg_q);
    dh_c = (dh_reg_q == '0) ? 13'd1 : (13'(dh_reg_q) > sh_c) ? sh_c : 13'(dh_reg_q);
  end
  always_ff @(posedge clk_i) begin
    sw_q <= sw_c; sh_q <= sh_c; dw_q <= dw_c; dh_q <= dh_c;
  end

  // column-sum memory
  sum_t          mem [MAX_DST_WIDTH];
  sum_t          rd_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  sum_t          wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // frame state
  logic [12:0] col_cnt_q, row_cnt_q, col_end_q, row_start_q, row_end_q;
  logic [12:0] dcol_q, drow_q;
  logic [12:0] first_cb_q;
  logic [AW-1:0] clr_q;
  logic [7:0]  pr_q, pg_q, pb_q;
  logic        restart_q;

  // bound unit
  logic        b_start, b_busy;
  logic [12:0] b_size, b_idx, b_n, b_res;
  bfd_bound u_bound (
    .clk_i, .rst_ni, .start_i(b_start), .size_i(b_size), .idx_i(b_idx),
    .n_i(b_n), .busy_o(b_busy), .res_o(b_res)
  );

  // divider
  div_req_t dreq;
  div_rsp_t drsp;
  bfd_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // emit bookkeeping
  logic [12:0] ex_q, lo_q, hi_q;
  logic        fend_q;
  logic [12:0] height, wdt;
  logic [25:0] area_w;

  assign height = (row_end_q - row_start_q == '0) ? 13'd1 : row_end_q - row_start_q;
  assign wdt    = (hi_q - lo_q == '0) ? 13'd1 : hi_q - lo_q;
  assign area_w = wdt * height;

  // output register
  logic        ov_q;
  logic [7:0]  or_q, og_q, ob_q;
  logic [5:0]  oc_q;
  logic [9:0]  orow_q;
  logic        olr_q, olf_q;

  assign in_stall_o  = (state_q != ST_IDLE) | cfg_wr | restart_q;
  assign out_valid_o = ov_q;
  assign out_red_o   = or_q;
  assign out_green_o = og_q;
  assign out_blue_o  = ob_q;
  assign dst_col_o   = oc_q;
  assign dst_row_o   = orow_q;
  assign last_of_row_o   = olr_q;
  assign last_of_frame_o = olf_q;

  logic acc_in;
  assign acc_in = in_valid_i & ~in_stall_o;

  always_comb begin
    state_d = state_q;
    we      = 1'b0;
    waddr   = dcol_q[AW-1:0];
    wdata   = rd_q;
    raddr   = dcol_q[AW-1:0];
    b_start = 1'b0;
    b_size  = sw_q;
    b_idx   = 13'd1;
    b_n     = dw_q;
    dreq    = '0;
    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        if (clr_q == AW'(MAX_DST_WIDTH - 1)) begin
          b_start = 1'b1;
          state_d = ST_INIT_C;
        end
      end
      ST_INIT_C: if (!b_busy) begin
        b_start = 1'b1;
        b_size  = sh_q;
        b_n     = dh_q;
        state_d = ST_INIT_R;
      end
      ST_INIT_R: if (!b_busy) state_d = ST_IDLE;
      ST_IDLE: if (acc_in) state_d = ST_ACC;
      ST_ACC: begin
        we = 1'b1;
        wdata.r = rd_q.r + SumW'(pr_q);
        wdata.g = rd_q.g + SumW'(pg_q);
        wdata.b = rd_q.b + SumW'(pb_q);
        if (col_cnt_q + 13'd1 >= sw_q) begin
          if (row_cnt_q + 13'd1 >= row_end_q) begin
            state_d = ST_EB0;
            b_start = 1'b1;
            b_idx   = 13'd0;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (col_cnt_q + 13'd1 >= col_end_q && dcol_q + 13'd1 < dw_q) begin
          b_start = 1'b1;
          b_idx   = dcol_q + 13'd2;
          state_d = ST_CBND;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CBND: if (!b_busy) state_d = ST_IDLE;
      ST_EB0: if (!b_busy) begin
        b_start = 1'b1;
        b_idx   = ex_q + 13'd1;
        state_d = ST_EB1;
      end
      ST_EB1: begin
        raddr = ex_q[AW-1:0];
        if (!b_busy) state_d = ST_ERD;
      end
      ST_ERD: begin
        dreq.start = 1'b1;
        dreq.r     = rd_q.r;
        dreq.g     = rd_q.g;
        dreq.b     = rd_q.b;
        dreq.area  = area_w[22:0];
        we         = 1'b1;
        waddr      = ex_q[AW-1:0];
        wdata      = '0;
        state_d    = ST_EDIV;
      end
      ST_EDIV: if (drsp.done) state_d = ST_EOUT;
      ST_EOUT: if (!ov_q || !out_stall_i) begin
        if (ex_q + 13'd1 == dw_q) begin
          if (fend_q || row_cnt_q + 13'd1 >= sh_q) begin
            state_d = ST_CLEAR;
          end else begin
            b_start = 1'b1;
            b_size  = sh_q;
            b_idx   = drow_q + 13'd2;
            b_n     = dh_q;
            state_d = ST_INIT_R;
          end
        end else begin
          b_start = 1'b1;
          b_idx   = ex_q + 13'd2;
          state_d = ST_EB1;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
    if (restart_q) state_d = ST_CLEAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      restart_q   <= 1'b0;
      clr_q       <= '0;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      dcol_q      <= '0;
      drow_q      <= '0;
      row_start_q <= '0;
      col_end_q   <= '0;
      row_end_q   <= '0;
      ex_q        <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      fend_q      <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      // register the write so the effective sizes settle before the restart
      restart_q <= cfg_wr;
      state_q   <= state_d;
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          col_cnt_q <= '0; row_cnt_q <= '0; dcol_q <= '0; drow_q <= '0;
          row_start_q <= '0;
        end
        ST_INIT_C: if (!b_busy) col_end_q <= b_res;
        ST_INIT_R: if (!b_busy) row_end_q <= b_res;
        ST_ACC: begin
          if (col_cnt_q + 13'd1 >= sw_q) begin
            col_cnt_q <= '0;
            // the next source row starts at the first column boundary again
            col_end_q <= first_cb_q;
            if (row_cnt_q + 13'd1 >= row_end_q) begin
              ex_q   <= '0;
              fend_q <= (row_end_q >= sh_q) || (row_cnt_q + 13'd1 >= sh_q);
            end else begin
              row_cnt_q <= row_cnt_q + 13'd1;
            end
          end else begin
            col_cnt_q <= col_cnt_q + 13'd1;
          end
        end
        ST_CBND: if (!b_busy) begin
          col_end_q <= b_res;
          dcol_q    <= dcol_q + 13'd1;
        end
        ST_EB0: if (!b_busy) lo_q <= b_res;
        ST_EB1: if (!b_busy) hi_q <= b_res;
        ST_EOUT: if (!ov_q || !out_stall_i) begin
          ov_q   <= 1'b1;
          or_q   <= pr_q;
          og_q   <= pg_q;
          ob_q   <= pb_q;
          oc_q   <= ex_q[5:0];
          orow_q <= drow_q[9:0];
          olr_q  <= (ex_q + 13'd1 == dw_q);
          olf_q  <= (ex_q + 13'd1 == dw_q) && fend_q;
          lo_q   <= hi_q;
          ex_q   <= ex_q + 13'd1;
          if (ex_q + 13'd1 == dw_q) begin
            dcol_q <= '0;
            if (!(fend_q || row_cnt_q + 13'd1 >= sh_q)) begin
              drow_q      <= drow_q + 13'd1;
              row_start_q <= row_end_q;
              row_cnt_q   <= row_cnt_q + 13'd1;
            end
          end
        end
        default: ;
      endcase
      if (state_q == ST_ACC && col_cnt_q + 13'd1 >= sw_q) dcol_q <= '0;
      if (state_q == ST_ACC && col_cnt_q + 13'd1 >= sw_q &&
          !(row_cnt_q + 13'd1 >= row_end_q) && row_cnt_q + 13'd1 >= sh_q) begin
        state_q <= ST_CLEAR;
      end
      if (restart_q) clr_q <= '0;
    end
  end

  // first column boundary for each new row; pixel and quotient holding registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_INIT_C && !b_busy) first_cb_q <= b_res;
    if (state_q == ST_IDLE && acc_in) begin
      pr_q <= red_i; pg_q <= green_i; pb_q <= blue_i;
    end
    if (state_q == ST_EDIV && drsp.done) begin
      pr_q <= drsp.r; pg_q <= drsp.g; pb_q <= drsp.b;
    end
  end
endmodule

>>> rtl/core/bfd_bound.sv
// ----------------------------------------------------------------------------
// bfd_bound
// Iterative floor(size*idx/n): one multiply, then restoring division one
// quotient bit a cycle.
// ----------------------------------------------------------------------------
module bfd_bound import bfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [12:0] size_i,
  input  logic [12:0] idx_i,
  input  logic [12:0] n_i,
  output logic        busy_o,
  output logic [12:0] res_o
);
  localparam int unsigned NumW = 26;

  logic [NumW-1:0] num_q, num_d;
  logic [12:0]     den_q, den_d;
  logic [13:0]     rem_q, rem_d;
  logic [4:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [13:0]     trial;

  assign trial = {rem_q[12:0], num_q[NumW-1]};

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      num_d  = size_i * idx_i;
      den_d  = n_i;
      rem_d  = '0;
      cnt_d  = 5'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign res_o  = num_q[12:0];
endmodule

>>> rtl/core/bfd_div.sv
// ----------------------------------------------------------------------------
// bfd_div
// Three-channel restoring divider, one quotient bit per cycle, shared divisor.
// ----------------------------------------------------------------------------
module bfd_div import bfd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic [SumW-1:0] nr_q, ng_q, nb_q;
  logic [23:0]     rr_q, rg_q, rb_q;
  logic [22:0]     den_q;
  logic [4:0]      cnt_q;
  logic            busy_q, done_q;
  logic [23:0]     tr, tg, tb;

  assign tr = {rr_q[22:0], nr_q[SumW-1]};
  assign tg = {rg_q[22:0], ng_q[SumW-1]};
  assign tb = {rb_q[22:0], nb_q[SumW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(SumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      nr_q <= req_i.r; ng_q <= req_i.g; nb_q <= req_i.b;
      rr_q <= '0; rg_q <= '0; rb_q <= '0;
      den_q <= req_i.area;
    end else if (busy_q) begin
      if (tr >= {1'b0, den_q}) begin
        rr_q <= tr - {1'b0, den_q}; nr_q <= {nr_q[SumW-2:0], 1'b1};
      end else begin
        rr_q <= tr; nr_q <= {nr_q[SumW-2:0], 1'b0};
      end
      if (tg >= {1'b0, den_q}) begin
        rg_q <= tg - {1'b0, den_q}; ng_q <= {ng_q[SumW-2:0], 1'b1};
      end else begin
        rg_q <= tg; ng_q <= {ng_q[SumW-2:0], 1'b0};
      end
      if (tb >= {1'b0, den_q}) begin
        rb_q <= tb - {1'b0, den_q}; nb_q <= {nb_q[SumW-2:0], 1'b1};
      end else begin
        rb_q <= tb; nb_q <= {nb_q[SumW-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.r    = nr_q[PixW-1:0];
  assign rsp_o.g    = ng_q[PixW-1:0];
  assign rsp_o.b    = nb_q[PixW-1:0];
endmodule

>>> tb/downscale_checker.sv
// ----------------------------------------------------------------------------
// downscale_checker
// Watches the pixel channels of the downscaler, predicts every destination
// pixel from the accepted source pixels and the register settings, and
// compares the transfers field by field.
// ----------------------------------------------------------------------------
module downscale_checker import bfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [7:0]  out_red_o,
  input  logic [7:0]  out_green_o,
  input  logic [7:0]  out_blue_o,
  input  logic [5:0]  dst_col_o,
  input  logic [9:0]  dst_row_o,
  input  logic        last_of_row_o,
  input  logic        last_of_frame_o,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [5:0] col;
    logic [9:0] row;
    logic       lrow;
    logic       lframe;
  } dst_pix_t;

  dst_pix_t pixel_queue[$];

  logic [10:0] reg_sw, reg_sh, reg_dh;
  logic [6:0]  reg_dw;
  int unsigned col_cnt, row_cnt, dcol, dcol_end, drow, band_start, band_end;
  logic [SumW-1:0] acc_r[MaxDstWidth], acc_g[MaxDstWidth], acc_b[MaxDstWidth];

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned eff_sw();
    return clip(32'(reg_sw), 1, MaxSrcWidth);
  endfunction
  function automatic int unsigned eff_sh();
    return clip(32'(reg_sh), 1, MaxSrcHeight);
  endfunction
  function automatic int unsigned eff_dw();
    return clip(32'(reg_dw), 1, eff_sw() < MaxDstWidth ? eff_sw() : MaxDstWidth);
  endfunction
  function automatic int unsigned eff_dh();
    return clip(32'(reg_dh), 1, eff_sh());
  endfunction

  function automatic int unsigned edge_at(int unsigned size, int unsigned idx, int unsigned n);
    longint unsigned p;
    p = 64'(size) * 64'(idx);
    return 32'(p / 64'(n));
  endfunction

  task automatic restart_frame();
    col_cnt = 0; row_cnt = 0; dcol = 0; drow = 0; band_start = 0;
    dcol_end = edge_at(eff_sw(), 1, eff_dw());
    band_end = edge_at(eff_sh(), 1, eff_dh());
    for (int i = 0; i < MaxDstWidth; i++) begin
      acc_r[i] = '0; acc_g[i] = '0; acc_b[i] = '0;
    end
  endtask

  task automatic add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned sw, sh, dw, dh, c, hgt, w, area;
    logic fend;
    dst_pix_t p;
    sw = eff_sw(); sh = eff_sh(); dw = eff_dw(); dh = eff_dh();
    c = dcol % MaxDstWidth;
    acc_r[c] = acc_r[c] + SumW'(r);
    acc_g[c] = acc_g[c] + SumW'(g);
    acc_b[c] = acc_b[c] + SumW'(b);
    if (col_cnt + 1 >= sw) begin
      col_cnt = 0; dcol = 0;
      dcol_end = edge_at(sw, 1, dw);
      if (row_cnt + 1 >= band_end) begin
        hgt = band_end - band_start;
        if (hgt == 0) hgt = 1;
        fend = (band_end >= sh) || (row_cnt + 1 >= sh);
        for (int x = 0; x < dw; x++) begin
          w = edge_at(sw, x + 1, dw) - edge_at(sw, x, dw);
          if (w == 0) w = 1;
          area = w * hgt;
          p.r = 8'(acc_r[x] / area);
          p.g = 8'(acc_g[x] / area);
          p.b = 8'(acc_b[x] / area);
          p.col = 6'(x);
          p.row = 10'(drow);
          p.lrow = (x + 1 == dw);
          p.lframe = (x + 1 == dw) && fend;
          pixel_queue.push_back(p);
          acc_r[x] = '0; acc_g[x] = '0; acc_b[x] = '0;
        end
        if (fend) begin
          restart_frame();
          return;
        end
        drow++;
        band_start = band_end;
        band_end = edge_at(sh, drow + 1, dh);
      end
      row_cnt++;
      if (row_cnt >= sh) restart_frame();
    end else begin
      col_cnt++;
      if (col_cnt >= dcol_end && dcol + 1 < dw) begin
        dcol++;
        dcol_end = edge_at(sw, dcol + 1, dw);
      end
    end
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending_count = pixel_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    dst_pix_t e;
    if (!rst_ni) begin
      reg_sw = 11'd64; reg_sh = 11'd64; reg_dw = 7'd16; reg_dh = 11'd16;
      restart_frame();
      pixel_queue.delete();
      fail_count = 0;
    end else begin
      // output first: a pixel taken in this edge cannot emit on the same edge
      if (out_valid_o && !out_stall_i) begin
        if (pixel_queue.size() == 0) begin
          $error("unexpected destination pixel col %0d row %0d", dst_col_o, dst_row_o);
          fail_count++;
        end else begin
          e = pixel_queue.pop_front();
          check_field("out_red", 32'(e.r), 32'(out_red_o));
          check_field("out_green", 32'(e.g), 32'(out_green_o));
          check_field("out_blue", 32'(e.b), 32'(out_blue_o));
          check_field("dst_col", 32'(e.col), 32'(dst_col_o));
          check_field("dst_row", 32'(e.row), 32'(dst_row_o));
          check_field("last_of_row", 32'(e.lrow), 32'(last_of_row_o));
          check_field("last_of_frame", 32'(e.lframe), 32'(last_of_frame_o));
        end
      end
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          RegSrcWidth:  reg_sw = pwdata[10:0];
          RegSrcHeight: reg_sh = pwdata[10:0];
          RegDstWidth:  reg_dw = pwdata[6:0];
          RegDstHeight: reg_dh = pwdata[10:0];
          default: ;
        endcase
        restart_frame();
      end
      if (in_valid_i && !in_stall_o) add_pixel(red_i, green_i, blue_i);
    end
  end
endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives source frames into the box filter downscaler under several size
// settings with random gaps and stalls; a checker predicts and compares every
// destination pixel, and this module reports the verdict.
// ----------------------------------------------------------------------------
module testbench import bfd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  red_i = '0, green_i = '0, blue_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_red_o, out_green_o, out_blue_o;
  logic [5:0]  dst_col_o;
  logic [9:0]  dst_row_o;
  logic        last_of_row_o, last_of_frame_o;
  int          fail_count, pending_count;
  bit          long_hold = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  box_filter_image_downscaler_core uut (.*);
  downscale_checker scoreboard (.*);

  // Write one register: setup cycle, then access cycle.
  task automatic write_reg(logic [1:0] idx, int unsigned value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Offer one source pixel, after a random gap if gaps is set; hold it until the transfer.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(13, 0) : 0;
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    red_i <= r; green_i <= g; blue_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Wait until every predicted pixel has left, then let the divider settle.
  task automatic drain();
    drop_valid();
    while (pending_count != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic configure(int unsigned sw, int unsigned sh, int unsigned dw,
                           int unsigned dh);
    write_reg(RegSrcWidth, sw);
    write_reg(RegSrcHeight, sh);
    write_reg(RegDstWidth, dw);
    write_reg(RegDstHeight, dh);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic random_pixels(int unsigned count, bit gaps);
    for (int i = 0; i < count; i++)
      send_pixel(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                 8'($urandom_range(255, 0)), gaps);
  endtask

  // Receiver: stall for a random number of cycles per pixel; during the long
  // hold-off stall outright so the block backs up into its input.
  always @(negedge clk_i) begin
    int unsigned wait_left;
    if (long_hold) begin
      out_stall_i <= 1'b1;
    end else if (wait_left != 0) begin
      wait_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (out_valid_o) wait_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(13, 0);
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (150) @(posedge clk_i);

    // Extremes of channel values on a 2x2 -> 1x1 box, no gaps.
    configure(2, 2, 1, 1);
    send_pixel(8'hff, 8'h00, 8'hff, 0);
    send_pixel(8'hff, 8'h00, 8'h00, 0);
    send_pixel(8'hff, 8'h00, 8'hff, 0);
    send_pixel(8'hff, 8'h00, 8'hfe, 0);
    send_pixel(8'h00, 8'hff, 8'h55, 0);
    send_pixel(8'h00, 8'hff, 8'haa, 0);
    send_pixel(8'h01, 8'hff, 8'h00, 0);
    send_pixel(8'h80, 8'hfe, 8'h7f, 0);
    drain();

    // Upscale request and zero destination sizes get clamped.
    configure(3, 2, 100, 0);
    random_pixels(6, 0);
    drain();
    configure(0, 3, 0, 2000);
    random_pixels(3, 0);
    drain();

    // Wide row: 64 destination columns from 64 source columns, 1 row.
    configure(64, 1, 64, 1);
    random_pixels(64, 1);
    drain();

    // Random body: small frame with uneven ratios.
    configure(7, 2, 3, 2);
    random_pixels(14, 1);
    drain();

    // Long receiver hold-off while the sender keeps offering.
    configure(5, 2, 5, 2);
    fork
      random_pixels(10, 0);
      begin
        long_hold = 1'b1;
        repeat (3000) @(posedge clk_i);
        long_hold = 1'b0;
      end
    join
    drain();

    // Out-of-range source and destination sizes, few pixels consumed.
    configure(2047, 2047, 127, 1);
    random_pixels(3, 1);
    drain();
    // Mid-frame reconfig, restart at 4x2 -> 2x2.
    configure(4, 2, 2, 2);
    random_pixels(8, 1);
    drain();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("FAIL");
    $finish;
  end
endmodule

>>> sim.f
rtl/core/bfd_pkg.sv
rtl/core/bfd_bound.sv
rtl/core/bfd_div.sv
rtl/core/box_filter_image_downscaler_core.sv
tb/downscale_checker.sv
tb/testbench.sv
